// File: sv/edla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edla_pkg;

  // Size defaults.
  localparam int FRAME_MAX_DEF = 32;
  localparam int LINE_MAX_DEF  = 32;
  localparam int DESC_DEPTH    = 2;
  localparam int OUT_DEPTH     = 4;
  // Widest frame position a descriptor carries (FRAME_MAX is at most 32).
  localparam int DPOS_W        = 5;

  // Frame bytes.
  localparam logic [7:0] START_BYTE  = 8'h02;
  localparam logic [7:0] TYPE_BLE    = 8'h08;
  localparam logic [7:0] TYPE_SPP    = 8'h07;
  localparam logic [7:0] TYPE_STATUS = 8'h02;
  localparam logic [7:0] TYPE_CLOSED = 8'h05;
  localparam logic [7:0] LINK_BITS   = 8'h30;
  localparam logic [7:0] VIS_BITS    = 8'h07;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SP       = 8'h20;

  // Payload start positions inside a frame.
  localparam logic [DPOS_W-1:0] BLE_START = 5'd5;
  localparam logic [DPOS_W-1:0] SPP_START = 5'd3;

  typedef enum logic [1:0] {
    DK_DATA,
    DK_STATUS,
    DK_CLOSED
  } desc_kind_t;

  typedef enum logic [1:0] {
    RK_CHAR   = 2'd0,
    RK_STATUS = 2'd1,
    RK_CLOSED = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ONE,
    BK_FRD,
    BK_FPROC,
    BK_ERD,
    BK_EWR,
    BK_DONE
  } bk_state_t;

  // One finished frame, handed from front to back.
  typedef struct packed {
    desc_kind_t        kind;
    logic              ch;
    logic              bank;
    logic [DPOS_W-1:0] start;
    logic [DPOS_W-1:0] n;
    logic [7:0]        stat;
  } desc_t;

  // Back returns a frame bank once it has replayed it.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    res_kind_t  kind;
    logic       channel;
    logic [7:0] char_code;
    logic       line_end;
    logic [7:0] status_bits;
    logic       link_online;
    logic       readvertise;
    logic       run_last;
  } res_t;

endpackage
`default_nettype wire

// File: sv/edla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module edla_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/edla_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module edla_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic      [W-1:0] dout,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// File: sv/edla_front.sv
`timescale 1ns / 1ps
`default_nettype none
module edla_front
  import edla_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  frm_we,
  output logic      [$clog2(FRAME_MAX):0]       frm_waddr,
  output logic      [7:0]                       frm_wdata,
  input  wire logic                             desc_full,
  output logic                                  desc_push,
  output desc_t                                 desc_out,
  input  wire rel_t                             rel
);

  localparam int PW = $clog2(FRAME_MAX);
  localparam int CW = PW + 1;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    typ_r, typ_nxt, len_r, len_nxt, stat_r, stat_nxt;
  logic          wr_bank_r, wr_bank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          accept, done, want;
  logic [CW-1:0] c1;
  logic [7:0]    len_eff, stat_eff;

  assign full      = desc_full || busy_r[wr_bank_r];
  assign accept    = push && !full;
  assign c1        = cnt_r + 1'b1;
  assign len_eff   = (cnt_r == CW'(2)) ? rx_byte : len_r;
  assign stat_eff  = (cnt_r == CW'(3)) ? rx_byte : stat_r;
  assign done      = (cnt_r >= CW'(2)) && (9'(c1) == 9'd3 + {1'b0, len_eff});
  assign frm_we    = accept && (cnt_r >= CW'(3));
  assign frm_waddr = {wr_bank_r, cnt_r[PW-1:0]};
  assign frm_wdata = rx_byte;

  // Classify the finished frame.
  always_comb begin
    desc_out      = '0;
    desc_out.kind = DK_DATA;
    desc_out.bank = wr_bank_r;
    desc_out.stat = stat_eff;
    want          = 1'b0;
    case (typ_r)
      TYPE_BLE: begin
        desc_out.ch    = 1'b0;
        desc_out.start = BLE_START;
        desc_out.n     = DPOS_W'(len_eff - 8'd2);
        want           = (len_eff >= 8'd3);
      end
      TYPE_SPP: begin
        desc_out.ch    = 1'b1;
        desc_out.start = SPP_START;
        desc_out.n     = DPOS_W'(len_eff);
        want           = (len_eff != 8'd0);
      end
      TYPE_STATUS: begin
        desc_out.kind = DK_STATUS;
        want          = (len_eff != 8'd0);
      end
      TYPE_CLOSED: begin
        desc_out.kind = DK_CLOSED;
        want          = 1'b1;
      end
      default: want = 1'b0;
    endcase
  end

  assign desc_push = accept && done && want;

  always_comb begin
    cnt_nxt     = cnt_r;
    typ_nxt     = typ_r;
    len_nxt     = len_r;
    stat_nxt    = stat_r;
    wr_bank_nxt = wr_bank_r;
    busy_nxt    = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (cnt_r == '0) begin
        if (rx_byte == START_BYTE) begin
          cnt_nxt = CW'(1);
        end
      end else begin
        if (cnt_r == CW'(1)) typ_nxt = rx_byte;
        if (cnt_r == CW'(2)) len_nxt = rx_byte;
        if (cnt_r == CW'(3)) stat_nxt = rx_byte;
        if (done) begin
          cnt_nxt = '0;
          if (desc_push && desc_out.kind == DK_DATA) begin
            busy_nxt[wr_bank_r] = 1'b1;
            wr_bank_nxt         = !wr_bank_r;
          end
        end else if (c1 >= CW'(FRAME_MAX)) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = c1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      wr_bank_r <= wr_bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    typ_r  <= typ_nxt;
    len_r  <= len_nxt;
    stat_r <= stat_nxt;
  end

  a_rel_held: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> busy_r[rel.bank])
    else $error("bank released that was not held");
  a_desc_room: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> !desc_full)
    else $error("frame committed into a full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CW'(FRAME_MAX))
    else $error("frame count past limit");

endmodule
`default_nettype wire

// File: sv/edla_back.sv
`timescale 1ns / 1ps
`default_nettype none
module edla_back
  import edla_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF,
  parameter int LINE_MAX  = LINE_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       desc_empty,
  output logic                            desc_pop,
  input  wire desc_t                      desc_in,
  output logic                            frm_re,
  output logic      [$clog2(FRAME_MAX):0] frm_raddr,
  input  wire logic [7:0]                 frm_rdata,
  output rel_t                            rel,
  input  wire logic                       out_full,
  output logic                            out_push,
  output res_t                            out_res
);

  localparam int PW = $clog2(FRAME_MAX);
  localparam int LW = $clog2(LINE_MAX);
  localparam logic [LW:0] LMAX = (LW + 1)'(LINE_MAX);

  bk_state_t         state_r, state_nxt;
  desc_t             d_r, d_nxt;
  logic [DPOS_W-1:0] i_r, i_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic [LW:0]       len_r [2];
  logic [LW:0]       len_nxt [2];
  logic [LW:0]       trim_r [2];
  logic [LW:0]       trim_nxt [2];
  res_t              hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;

  logic              lw_en, lr_en;
  logic [LW:0]       lw_addr, lr_addr;
  logic [7:0]        lr_data;

  logic              ch, last_i, online, is_end;
  res_t              one_res, char_res;

  assign ch     = d_r.ch;
  assign last_i = (i_r == d_r.n - 1'b1);
  assign online = (d_r.stat & LINK_BITS) != 8'h00;
  assign is_end = ({1'b0, k_r} + 1'b1) == trim_r[ch];

  always_comb begin
    one_res = '0;
    if (d_r.kind == DK_CLOSED) begin
      one_res.kind = RK_CLOSED;
    end else begin
      one_res.kind        = RK_STATUS;
      one_res.status_bits = d_r.stat;
      one_res.link_online = online;
      one_res.readvertise = !online && ((d_r.stat & VIS_BITS) != VIS_BITS);
    end
    one_res.run_last = 1'b1;
  end

  always_comb begin
    char_res           = '0;
    char_res.kind      = RK_CHAR;
    char_res.channel   = ch;
    char_res.char_code = lr_data;
    char_res.line_end  = is_end;
  end

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    len_nxt    = len_r;
    trim_nxt   = trim_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    desc_pop   = 1'b0;
    frm_re     = 1'b0;
    frm_raddr  = {d_r.bank, d_r.start[PW-1:0] + i_r[PW-1:0]};
    lw_en      = 1'b0;
    lw_addr    = {ch, len_r[ch][LW-1:0]};
    lr_en      = 1'b0;
    lr_addr    = {ch, k_r};
    out_push   = 1'b0;
    out_res    = hold_r;
    rel        = '0;
    case (state_r)
      BK_IDLE: begin
        if (!desc_empty) begin
          desc_pop  = 1'b1;
          d_nxt     = desc_in;
          i_nxt     = '0;
          state_nxt = (desc_in.kind == DK_DATA) ? BK_FRD : BK_ONE;
        end
      end
      BK_ONE: begin
        if (!out_full) begin
          out_push = 1'b1;
          out_res  = one_res;
          if (d_r.kind == DK_CLOSED || online) begin
            len_nxt[0]  = '0;
            len_nxt[1]  = '0;
            trim_nxt[0] = '0;
            trim_nxt[1] = '0;
          end
          state_nxt = BK_IDLE;
        end
      end
      BK_FRD: begin
        frm_re    = 1'b1;
        state_nxt = BK_FPROC;
      end
      BK_FPROC: begin
        if (frm_rdata == CH_NL && trim_r[ch] != '0) begin
          k_nxt     = '0;
          state_nxt = BK_ERD;
        end else begin
          if (frm_rdata == CH_NL) begin
            len_nxt[ch]  = '0;
            trim_nxt[ch] = '0;
          end else if (len_r[ch] < LMAX) begin
            lw_en       = 1'b1;
            len_nxt[ch] = len_r[ch] + 1'b1;
            if (!(frm_rdata inside {CH_CR, CH_SP})) begin
              trim_nxt[ch] = len_r[ch] + 1'b1;
            end
          end
          if (last_i) begin
            state_nxt = BK_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = BK_FRD;
          end
        end
      end
      BK_ERD: begin
        if (!out_full) begin
          lr_en     = 1'b1;
          state_nxt = BK_EWR;
        end
      end
      BK_EWR: begin
        // Hold the newest character back until the next one shows it is not last.
        out_push   = hold_v_r;
        hold_nxt   = char_res;
        hold_v_nxt = 1'b1;
        if (is_end) begin
          len_nxt[ch]  = '0;
          trim_nxt[ch] = '0;
          if (last_i) begin
            state_nxt = BK_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = BK_FRD;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = BK_ERD;
        end
      end
      BK_DONE: begin
        if (!hold_v_r || !out_full) begin
          out_push         = hold_v_r;
          out_res.run_last = 1'b1;
          hold_v_nxt       = 1'b0;
          rel.valid        = 1'b1;
          rel.bank         = d_r.bank;
          state_nxt        = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      len_r    <= '{default: '0};
      trim_r   <= '{default: '0};
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      trim_r   <= trim_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    hold_r <= hold_nxt;
  end

  edla_ram #(
    .W     (8),
    .DEPTH (2 ** (LW + 1))
  ) u_line_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (frm_rdata),
    .re    (lr_en),
    .raddr (lr_addr),
    .rdata (lr_data)
  );

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");
  a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EWR |-> $past(state_r) == BK_ERD)
    else $error("line character taken without a read");
  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    len_r[0] <= LMAX && trim_r[0] <= len_r[0] && len_r[1] <= LMAX && trim_r[1] <= len_r[1])
    else $error("line length bookkeeping out of order");

endmodule
`default_nettype wire

// File: sv/event_deframer_line_assembler.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+--------------------------------------
// input     | in        | push / full          | in_rx_byte: one received byte
// result    | out       | empty / pop          | out_kind .. out_run_last: one event
//
// The front takes one byte per cycle while full is low and writes payload bytes
// into one of two frame banks; a finished frame goes to the back as a descriptor
// in a 2-deep queue. The back replays each payload byte via BK_FRD and BK_FPROC,
// reads out each line character via BK_ERD and BK_EWR, takes each descriptor in
// BK_IDLE and ends a data frame in BK_DONE, a status or link-closed event in BK_ONE.
// full rises while the descriptor queue is full or the bank for the next frame
// is still being replayed; the 4-deep result queue lets the back run ahead of pop.
// rst_n is synchronous; no clearing pass, the block takes bytes right after reset.
module event_deframer_line_assembler
  import edla_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF,
  parameter int LINE_MAX  = LINE_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic      [1:0] out_kind,
  output logic            out_channel,
  output logic      [7:0] out_char_code,
  output logic            out_line_end,
  output logic      [7:0] out_status_bits,
  output logic            out_link_online,
  output logic            out_readvertise,
  output logic            out_run_last
);

  localparam int FAW = $clog2(FRAME_MAX) + 1;

  // front -> frame banks
  logic           frm_we;
  logic [FAW-1:0] frm_waddr;
  logic [7:0]     frm_wdata;
  // back <- frame banks
  logic           frm_re;
  logic [FAW-1:0] frm_raddr;
  logic [7:0]     frm_rdata;

  // descriptor queue
  logic           desc_push, desc_full, desc_pop, desc_empty;
  desc_t          desc_w, desc_r;
  logic [$bits(desc_t)-1:0] desc_q;

  rel_t           rel;

  // result queue
  logic           res_push, res_full;
  res_t           res_w, res_r;
  logic [$bits(res_t)-1:0] res_q;

  edla_front #(
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .rx_byte   (in_rx_byte),
    .frm_we    (frm_we),
    .frm_waddr (frm_waddr),
    .frm_wdata (frm_wdata),
    .desc_full (desc_full),
    .desc_push (desc_push),
    .desc_out  (desc_w),
    .rel       (rel)
  );

  // Two frame banks: the front fills one while the back replays the other.
  edla_ram #(
    .W     (8),
    .DEPTH (2 ** FAW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  edla_fifo #(
    .W     ($bits(desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc_w),
    .full  (desc_full),
    .pop   (desc_pop),
    .dout  (desc_q),
    .empty (desc_empty)
  );

  assign desc_r = desc_t'(desc_q);

  edla_back #(
    .FRAME_MAX (FRAME_MAX),
    .LINE_MAX  (LINE_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .desc_in    (desc_r),
    .frm_re     (frm_re),
    .frm_raddr  (frm_raddr),
    .frm_rdata  (frm_rdata),
    .rel        (rel),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_res    (res_w)
  );

  // Hold finished events until the consumer pops them.
  edla_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_w),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign res_r           = res_t'(res_q);
  assign out_kind        = res_r.kind;
  assign out_channel     = res_r.channel;
  assign out_char_code   = res_r.char_code;
  assign out_line_end    = res_r.line_end;
  assign out_status_bits = res_r.status_bits;
  assign out_link_online = res_r.link_online;
  assign out_readvertise = res_r.readvertise;
  assign out_run_last    = res_r.run_last;

endmodule
`default_nettype wire

// File: dv/tb_event_deframer_line_assembler.sv
`timescale 1ns / 1ps
module tb_event_deframer_line_assembler;
  import edla_pkg::*;

  // Longest stretch with no word moving on either side before the run is aborted.
  localparam int QUIET_LIMIT = 2000;
  // Receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 260;
  // Random bytes after the directed part.
  localparam int RANDOM_BYTES = 50;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_kind;
  logic       out_channel;
  logic [7:0] out_char_code;
  logic       out_line_end;
  logic [7:0] out_status_bits;
  logic       out_link_online;
  logic       out_readvertise;
  logic       out_run_last;

  event_deframer_line_assembler u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_channel     (out_channel),
    .out_char_code   (out_char_code),
    .out_line_end    (out_line_end),
    .out_status_bits (out_status_bits),
    .out_link_online (out_link_online),
    .out_readvertise (out_readvertise),
    .out_run_last    (out_run_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bytes waiting to be offered, and events the block still owes us.
  logic [7:0] rx_bytes_q[$];
  logic [7:0] frame_body[$];
  res_t       events_due[$];

  // Shadow of the deframer and the two line stores.
  int         fr_count = 0;
  logic [7:0] fr_bytes [FRAME_MAX_DEF];
  logic [7:0] line_buf [2][LINE_MAX_DEF];
  int         line_len [2] = '{0, 0};

  int   n_in = 0;
  int   n_predicted = 0;
  int   n_fail = 0;
  int   n_chars = 0;
  int   n_lines = 0;
  int   n_status = 0;
  int   n_closed = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  res_t want;

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------

  task automatic emit_event(input res_kind_t kind, input bit ch, input logic [7:0] code,
                            input bit last_char, input logic [7:0] stat,
                            input bit onl, input bit rdv);
    res_t e;
    e.kind        = kind;
    e.channel     = ch;
    e.char_code   = code;
    e.line_end    = last_char;
    e.status_bits = stat;
    e.link_online = onl;
    e.readvertise = rdv;
    e.run_last    = 1'b0;
    events_due.push_back(e);
    n_predicted++;
  endtask

  // Replay payload bytes into a line store; a newline trims trailing CR/space and
  // flushes the line one character per event.
  task automatic feed_line_chars(input bit ch, input int start, input int count);
    int         i;
    int         k;
    int         len;
    logic [7:0] c;
    for (i = 0; i < count; i++) begin
      c = fr_bytes[(start + i) % FRAME_MAX_DEF];
      if (c == CH_NL) begin
        len = line_len[ch];
        while (len > 0 && (line_buf[ch][len-1] == CH_CR || line_buf[ch][len-1] == CH_SP))
          len--;
        for (k = 0; k < len; k++)
          emit_event(RK_CHAR, ch, line_buf[ch][k], k + 1 == len, 8'h00, 1'b0, 1'b0);
        line_len[ch] = 0;
      end else if (line_len[ch] < LINE_MAX_DEF) begin
        line_buf[ch][line_len[ch]] = c;
        line_len[ch]++;
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int         n0;
    logic [7:0] s;
    res_t       tail;
    n0 = events_due.size();
    // Skip everything outside a frame until a start byte shows up.
    if (fr_count != 0 || b == START_BYTE) begin
      if (fr_count < FRAME_MAX_DEF)
        fr_bytes[fr_count % FRAME_MAX_DEF] = b;
      fr_count++;
      if (fr_count >= 3 && fr_count == 3 + int'(fr_bytes[2])) begin
        case (fr_bytes[1])
          TYPE_BLE: begin
            // Skip the two-byte handle; shorter frames carry nothing.
            if (fr_bytes[2] >= 2)
              feed_line_chars(1'b0, BLE_START, int'(fr_bytes[2]) - 2);
          end
          TYPE_SPP: begin
            feed_line_chars(1'b1, SPP_START, int'(fr_bytes[2]));
          end
          TYPE_STATUS: begin
            if (fr_bytes[2] >= 1) begin
              s = fr_bytes[3];
              // A live link drops whatever both lines held so far.
              if ((s & LINK_BITS) != 8'h00) begin
                line_len[0] = 0;
                line_len[1] = 0;
              end
              emit_event(RK_STATUS, 1'b0, 8'h00, 1'b0, s, (s & LINK_BITS) != 8'h00,
                         (s & LINK_BITS) == 8'h00 && (s & VIS_BITS) != VIS_BITS);
            end
          end
          TYPE_CLOSED: begin
            line_len[0] = 0;
            line_len[1] = 0;
            emit_event(RK_CLOSED, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
          end
          default: begin
          end
        endcase
        fr_count = 0;
      end else if (fr_count >= FRAME_MAX_DEF) begin
        // Too long: drop the frame and hunt for the next start byte.
        fr_count = 0;
      end
    end
    // Mark the last event this byte caused.
    if (events_due.size() > n0) begin
      tail = events_due.pop_back();
      tail.run_last = 1'b1;
      events_due.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_raw(input logic [7:0] b);
    rx_bytes_q.push_back(b);
  endtask

  task automatic add_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++)
      frame_body.push_back(txt[i]);
  endtask

  task automatic add_handle();
    frame_body.push_back(8'($urandom));
    frame_body.push_back(8'($urandom));
  endtask

  // Wrap the collected payload into a complete frame.
  task automatic send_frame(input logic [7:0] kind);
    int i;
    add_raw(START_BYTE);
    add_raw(kind);
    add_raw(8'(frame_body.size()));
    for (i = 0; i < frame_body.size(); i++)
      add_raw(frame_body[i]);
    frame_body.delete();
  endtask

  // Claim a length that cannot fit and send bytes right up to the drop point.
  task automatic send_oversize(input logic [7:0] kind, input logic [7:0] len);
    add_raw(START_BYTE);
    add_raw(kind);
    add_raw(len);
    repeat (FRAME_MAX_DEF - 3) add_raw(8'($urandom));
  endtask

  // Mostly printable text, with plenty of line ends and blanks.
  function automatic logic [7:0] line_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50)
      line_char = 8'($urandom_range(8'h21, 8'h7E));
    else if (p < 65)
      line_char = CH_NL;
    else if (p < 75)
      line_char = CH_CR;
    else if (p < 90)
      line_char = CH_SP;
    else
      line_char = 8'($urandom);
  endfunction

  task automatic add_random_frame();
    int         r;
    int         n;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 29) : $urandom_range(0, 10);
      repeat (n) frame_body.push_back(line_char());
      send_frame(TYPE_SPP);
    end else if (r < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        // Too short to hold a handle.
        repeat ($urandom_range(0, 1)) frame_body.push_back(8'($urandom));
      end else begin
        add_handle();
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 27) : $urandom_range(0, 10);
        repeat (n) frame_body.push_back(line_char());
      end
      send_frame(TYPE_BLE);
    end else if (r < 78) begin
      // Keep most status bytes off-link so lines survive long enough to finish.
      t = 8'($urandom);
      if ($urandom_range(0, 2) != 0)
        t = t & ~LINK_BITS;
      n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n) begin
        frame_body.push_back(t);
        t = 8'($urandom);
      end
      send_frame(TYPE_STATUS);
    end else if (r < 82) begin
      repeat ($urandom_range(0, 2)) frame_body.push_back(8'($urandom));
      send_frame(TYPE_CLOSED);
    end else if (r < 86) begin
      do
        t = 8'($urandom);
      while (t == TYPE_BLE || t == TYPE_SPP || t == TYPE_STATUS || t == TYPE_CLOSED);
      repeat ($urandom_range(0, 5)) frame_body.push_back(8'($urandom));
      send_frame(t);
    end else if (r < 90) begin
      send_oversize($urandom_range(0, 1) ? TYPE_SPP : TYPE_BLE,
                    8'($urandom_range(30, 255)));
    end else begin
      // Line noise between frames; a stray start byte now and then.
      repeat ($urandom_range(1, 4)) begin
        t = 8'($urandom);
        if (t == START_BYTE && $urandom_range(0, 3) != 0)
          t = 8'h03;
        add_raw(t);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the head byte at the falling edge, hold it until taken.
  // ---------------------------------------------------------------------------

  bit         in_taken = 1'b0;
  bit         in_busy = 1'b1;
  int         in_gap = 0;
  logic [7:0] sent_byte;

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      sent_byte = rx_bytes_q.pop_front();
      deframe_byte(sent_byte);
      n_in++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      in_taken = 1'b0;
      // Switch between stretches with gaps and stretches without.
      if ($urandom_range(0, 47) == 0)
        in_busy = ~in_busy;
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (rx_bytes_q.size() == 0) begin
        push <= 1'b0;
      end else if (!calm && in_busy && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 8);
        push <= 1'b0;
      end else begin
        push       <= 1'b1;
        in_rx_byte <= rx_bytes_q[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each popped word against the oldest expected event.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (events_due.size() == 0) begin
        $error("unexpected word: kind %0d char_code %0h status_bits %0h",
               out_kind, out_char_code, out_status_bits);
        n_fail++;
      end else begin
        want = events_due.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_kind));
        check_field("channel", 8'(want.channel), 8'(out_channel));
        check_field("char_code", want.char_code, out_char_code);
        check_field("line_end", 8'(want.line_end), 8'(out_line_end));
        check_field("status_bits", want.status_bits, out_status_bits);
        check_field("link_online", 8'(want.link_online), 8'(out_link_online));
        check_field("readvertise", 8'(want.readvertise), 8'(out_readvertise));
        check_field("run_last", 8'(want.run_last), 8'(out_run_last));
        case (want.kind)
          RK_CHAR: begin
            n_chars++;
            if (want.line_end)
              n_lines++;
          end
          RK_STATUS: n_status++;
          default:   n_closed++;
        endcase
      end
    end
  end

  bit out_busy = 1'b1;
  bit pressure_done = 1'b0;
  int out_gap = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if ($urandom_range(0, 47) == 0)
      out_busy = ~out_busy;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!pressure_done && n_in >= HOLD_AFTER) begin
      // Stop draining for a long stretch so the block backs up into full.
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      pop <= 1'b0;
    end else if (!calm && out_busy && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d events outstanding",
                 quiet_cycles, events_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frames, random frames, drain, report.
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    int random_end;

    // Noise ahead of any frame, toggling every bit of the byte.
    add_raw(8'h00);
    add_raw(8'hFF);
    add_raw(8'h55);
    add_raw(8'hAA);
    // Plain lines on each channel, trailing blanks trimmed.
    add_text("Hi \r\n");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("ok\n");
    send_frame(TYPE_BLE);
    // Blank and empty lines emit nothing.
    add_text("\r  \n");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("\n");
    send_frame(TYPE_BLE);
    // Status with no payload, then status bytes around the link and visibility bits.
    send_frame(TYPE_STATUS);
    frame_body.push_back(8'h00);
    send_frame(TYPE_STATUS);
    frame_body.push_back(8'h07);
    send_frame(TYPE_STATUS);
    frame_body.push_back(8'hFF);
    send_frame(TYPE_STATUS);
    frame_body.push_back(8'h10);
    send_frame(TYPE_STATUS);
    // Partial lines wiped by a link status; the newlines then flush nothing.
    add_text("abc");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("de");
    send_frame(TYPE_BLE);
    frame_body.push_back(8'h30);
    send_frame(TYPE_STATUS);
    add_text("\n");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("\n");
    send_frame(TYPE_BLE);
    // Partial line wiped by link closed, and a link-closed frame with payload.
    add_text("xyz");
    send_frame(TYPE_SPP);
    send_frame(TYPE_CLOSED);
    add_text("\n");
    send_frame(TYPE_SPP);
    add_text("zz");
    send_frame(TYPE_CLOSED);
    // Unknown types are swallowed whole.
    add_text("q");
    send_frame(8'h11);
    send_frame(8'hFF);
    // BLE frames too short for the handle.
    send_frame(TYPE_BLE);
    add_text("h");
    send_frame(TYPE_BLE);
    // Frames that outgrow the buffer.
    send_oversize(TYPE_SPP, 8'hFF);
    send_oversize(TYPE_BLE, 8'd30);
    // Line overflow across two frames: only the first LINE_MAX characters survive.
    repeat (29) frame_body.push_back("a");
    send_frame(TYPE_SPP);
    repeat (10) frame_body.push_back("b");
    add_text("\n");
    send_frame(TYPE_SPP);
    // Longest frame that still completes.
    add_handle();
    for (i = 0; i < 26; i++)
      frame_body.push_back(8'(8'h41 + i));
    add_text("\n");
    send_frame(TYPE_BLE);
    // Extreme character values, two lines in one frame, channels interleaved.
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h80);
    frame_body.push_back(8'h7F);
    add_text("\n");
    send_frame(TYPE_SPP);
    add_text("a\nb \n");
    send_frame(TYPE_SPP);
    add_text("hel");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("wor");
    send_frame(TYPE_BLE);
    add_text("lo\n");
    send_frame(TYPE_SPP);
    add_handle();
    add_text("ld\n");
    send_frame(TYPE_BLE);
    // Status with extra payload bytes that must be ignored.
    frame_body.push_back(8'h27);
    frame_body.push_back(8'hAA);
    frame_body.push_back(8'h55);
    send_frame(TYPE_STATUS);

    random_end = rx_bytes_q.size() + RANDOM_BYTES;
    while (rx_bytes_q.size() < random_end)
      add_random_frame();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Run the tail of the stimulus with both sides at full speed.
    while (rx_bytes_q.size() > 60)
      @(posedge clk);
    calm = 1'b1;

    // Top up with more frames if too few events came out of it.
    do begin
      while (rx_bytes_q.size() > 0)
        @(posedge clk);
      if (n_predicted < 60)
        repeat (20) add_random_frame();
    end while (rx_bytes_q.size() > 0);

    while (events_due.size() > 0)
      @(posedge clk);
    // Let the back end finish any frame that causes no event.
    repeat (200) @(posedge clk);

    $display("%0d bytes sent; %0d line characters in %0d lines, %0d status, %0d link closed",
             n_in, n_chars, n_lines, n_status, n_closed);
    if (n_fail == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
